### src/hvt_pkg.sv
// ----------------------------------------------------------------------------
// hvt_pkg
// Shared types, widths and constants of the homogeneous vertex transform.
// ----------------------------------------------------------------------------
package hvt_pkg;

    // Coordinate and coefficient formats.
    localparam int COORD_W    = 16;
    localparam int FRAC_BITS  = 8;
    localparam int COEF_W     = 16;
    localparam int NUM_COLS   = 4;
    localparam int NUM_ROWS   = 4;
    localparam int ROW_W      = NUM_COLS * COEF_W;

    // Datapath widths.
    localparam int PROD_W     = COORD_W + COEF_W;
    localparam int SHIFT_W    = COEF_W + FRAC_BITS;
    localparam int TERM_W     = (PROD_W > SHIFT_W) ? PROD_W : SHIFT_W;
    localparam int ACC_W      = TERM_W + 2;
    localparam int DIV_W      = (ACC_W > 2 * FRAC_BITS + 1) ? ACC_W : 2 * FRAC_BITS + 1;
    localparam int Q_W        = COORD_W + 1;
    localparam int NUM_W      = DIV_W + FRAC_BITS;
    localparam int HI_W       = NUM_W - Q_W;
    localparam int CMP_W      = (HI_W > DIV_W) ? HI_W : DIV_W;
    localparam int DIV_STAGES = Q_W + 1;

    // Stream and register port widths.
    localparam int TDATA_W    = ((3 * COORD_W + 7) / 8) * 8;
    localparam int TUSER_W    = 2;
    localparam int APB_DATA_W = ROW_W;
    localparam int APB_ADDR_W = 5;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [COEF_W-1:0]  coef_t;
    typedef logic signed [PROD_W-1:0]  prod_t;
    typedef logic signed [ACC_W-1:0]   acc_t;
    typedef logic [ACC_W-1:0]          umag_t;
    typedef logic [DIV_W-1:0]          mag_t;
    typedef logic [Q_W-1:0]            quo_t;
    typedef logic [NUM_ROWS-1:0][ROW_W-1:0] matrix_t;

    // Register indexes of the configuration port.
    typedef enum logic [1:0] {
        REG_ROW_X = 2'd0,
        REG_ROW_Y = 2'd1,
        REG_ROW_Z = 2'd2,
        REG_ROW_W = 2'd3
    } reg_idx_t;

    // Control that travels down the pipeline beside the data.
    typedef struct packed {
        logic valid;
        logic w_zero;
    } hvt_ctl_t;

    // Reset matrix is the identity.
    localparam logic [ROW_W-1:0] ROW_X_RESET = ROW_W'(1) << FRAC_BITS;
    localparam logic [ROW_W-1:0] ROW_Y_RESET = ROW_W'(1) << (COEF_W + FRAC_BITS);
    localparam logic [ROW_W-1:0] ROW_Z_RESET = ROW_W'(1) << (2 * COEF_W + FRAC_BITS);
    localparam logic [ROW_W-1:0] ROW_W_RESET = ROW_W'(1) << (3 * COEF_W + FRAC_BITS);
    localparam matrix_t MATRIX_RESET = {ROW_W_RESET, ROW_Z_RESET, ROW_Y_RESET, ROW_X_RESET};

    // Divisor used when w is zero: it turns the divide into a plain shift right.
    localparam mag_t DEN_ZERO_W = DIV_W'(1) << (2 * FRAC_BITS);

    // Clamp limits as quotient magnitudes.
    localparam quo_t NEG_LIMIT = Q_W'(1) << (COORD_W - 1);
    localparam quo_t POS_LIMIT = NEG_LIMIT - Q_W'(1);

    // Coefficient of one matrix column.
    function automatic coef_t coef_at(input logic [ROW_W-1:0] row, input int unsigned col);
        return row[col * COEF_W +: COEF_W];
    endfunction

    // Magnitude of a signed sum; the most negative value maps correctly.
    function automatic umag_t abs_acc(input acc_t a);
        umag_t neg_a;
        neg_a = umag_t'(-a);
        return a[ACC_W-1] ? neg_a : umag_t'(a);
    endfunction

endpackage

### src/hvt_mac.sv
// ----------------------------------------------------------------------------
// hvt_mac
// Matrix multiply front end: products, two adder levels, then sign and
// magnitude split with the divisor selection, one register stage each.
// ----------------------------------------------------------------------------
module hvt_mac import hvt_pkg::*; (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     ce,
    input  logic                     in_valid,
    input  coord_t                   in_x,
    input  coord_t                   in_y,
    input  coord_t                   in_z,
    input  matrix_t                  matrix,
    output hvt_ctl_t                 ctl,
    output logic [2:0][DIV_W-1:0]    num_mag,
    output logic [2:0]               num_neg,
    output mag_t                     den
);

    coord_t vin [3];

    prod_t  prod_reg [3][NUM_COLS];
    acc_t   pair_reg [NUM_COLS][2];
    acc_t   acc_reg  [NUM_COLS];
    logic [2:0] stage_valid_reg;

    logic [2:0][DIV_W-1:0] mag_reg;
    logic [2:0]            neg_reg;
    mag_t                  den_reg;
    hvt_ctl_t              ctl_reg;

    logic [2:0][DIV_W-1:0] mag_next;
    logic [2:0]            neg_next;
    mag_t                  den_next;
    logic                  w_zero;

    assign vin[0] = in_x;
    assign vin[1] = in_y;
    assign vin[2] = in_z;

    // Stage one: one multiplier per coordinate and column.
    always_ff @(posedge aclk) begin
        if (ce) begin
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < NUM_COLS; c++) begin
                    prod_reg[r][c] <= vin[r] * coef_at(matrix[r], c);
                end
            end
        end
    end

    // Stage two: pairwise sums; the translation row scales the implied one.
    always_ff @(posedge aclk) begin
        if (ce) begin
            for (int c = 0; c < NUM_COLS; c++) begin
                pair_reg[c][0] <= ACC_W'(prod_reg[0][c]) + ACC_W'(prod_reg[1][c]);
                pair_reg[c][1] <= ACC_W'(prod_reg[2][c])
                                + (ACC_W'(coef_at(matrix[REG_ROW_W], c)) <<< FRAC_BITS);
            end
        end
    end

    // Stage three: full column sums.
    always_ff @(posedge aclk) begin
        if (ce) begin
            for (int c = 0; c < NUM_COLS; c++) begin
                acc_reg[c] <= pair_reg[c][0] + pair_reg[c][1];
            end
        end
    end

    // Stage four: result signs, numerator magnitudes and the divisor.
    always_comb begin
        w_zero = (acc_reg[3] == '0);
        for (int c = 0; c < 3; c++) begin
            neg_next[c] = acc_reg[c][ACC_W-1] ^ acc_reg[3][ACC_W-1];
            mag_next[c] = DIV_W'(abs_acc(acc_reg[c]));
        end
        den_next = w_zero ? DEN_ZERO_W : DIV_W'(abs_acc(acc_reg[3]));
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            mag_reg <= mag_next;
            neg_reg <= neg_next;
            den_reg <= den_next;
        end
    end

    // Valid bits of the four stages and the zero-w flag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_valid_reg <= '0;
            ctl_reg         <= '0;
        end else if (ce) begin
            stage_valid_reg <= {stage_valid_reg[1:0], in_valid};
            ctl_reg.valid   <= stage_valid_reg[2];
            ctl_reg.w_zero  <= w_zero;
        end
    end

    assign ctl     = ctl_reg;
    assign num_mag = mag_reg;
    assign num_neg = neg_reg;
    assign den     = den_reg;

endmodule

### src/hvt_div.sv
// ----------------------------------------------------------------------------
// hvt_div
// Pipelined restoring divider for one coordinate: an overflow check stage,
// then one quotient bit per stage, most significant bit first.
// ----------------------------------------------------------------------------
module hvt_div import hvt_pkg::*; (
    input  logic aclk,
    input  logic ce,
    input  mag_t num_mag,
    input  mag_t den,
    input  logic neg_in,
    output quo_t quo,
    output logic ovf,
    output logic neg
);

    logic [NUM_W-1:0] numer;
    logic [HI_W-1:0]  numer_hi;
    logic             ovf_first;

    mag_t rem_reg [DIV_STAGES];
    quo_t lo_reg  [DIV_STAGES];
    quo_t q_reg   [DIV_STAGES];
    mag_t den_reg [DIV_STAGES];
    logic ovf_reg [DIV_STAGES];
    logic neg_reg [DIV_STAGES];

    mag_t rem_next [DIV_STAGES];
    quo_t lo_next  [DIV_STAGES];
    quo_t q_next   [DIV_STAGES];
    mag_t den_next [DIV_STAGES];
    logic ovf_next [DIV_STAGES];
    logic neg_next [DIV_STAGES];

    // First stage: a quotient that needs more than Q_W bits is flagged here,
    // which leaves the starting remainder below the divisor.
    assign numer     = NUM_W'(num_mag) << FRAC_BITS;
    assign numer_hi  = numer[NUM_W-1:Q_W];
    assign ovf_first = CMP_W'(numer_hi) >= CMP_W'(den);

    always_comb begin
        logic [DIV_W:0] trial;
        logic [DIV_W:0] diff;
        logic           take;

        rem_next[0] = ovf_first ? '0 : DIV_W'(numer_hi);
        lo_next[0]  = numer[Q_W-1:0];
        q_next[0]   = '0;
        den_next[0] = den;
        ovf_next[0] = ovf_first;
        neg_next[0] = neg_in;

        // Each later stage brings down one numerator bit and subtracts if it can.
        for (int s = 1; s < DIV_STAGES; s++) begin
            trial = {rem_reg[s-1], lo_reg[s-1][Q_W-1]};
            diff  = trial - {1'b0, den_reg[s-1]};
            take  = (trial >= {1'b0, den_reg[s-1]});
            rem_next[s] = take ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
            lo_next[s]  = lo_reg[s-1] << 1;
            q_next[s]   = {q_reg[s-1][Q_W-2:0], take};
            den_next[s] = den_reg[s-1];
            ovf_next[s] = ovf_reg[s-1];
            neg_next[s] = neg_reg[s-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            for (int s = 0; s < DIV_STAGES; s++) begin
                rem_reg[s] <= rem_next[s];
                lo_reg[s]  <= lo_next[s];
                q_reg[s]   <= q_next[s];
                den_reg[s] <= den_next[s];
                ovf_reg[s] <= ovf_next[s];
                neg_reg[s] <= neg_next[s];
            end
        end
    end

    assign quo = q_reg[DIV_STAGES-1];
    assign ovf = ovf_reg[DIV_STAGES-1];
    assign neg = neg_reg[DIV_STAGES-1];

endmodule

### src/hvt_out.sv
// ----------------------------------------------------------------------------
// hvt_out
// Saturation and encoding of the three quotients, followed by the output
// register and a skid register that decouple the pipeline from m_tready.
// ----------------------------------------------------------------------------
module hvt_out import hvt_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  hvt_ctl_t               tail_ctl,
    input  logic [2:0][Q_W-1:0]    quo,
    input  logic [2:0]             ovf,
    input  logic [2:0]             neg,
    output logic                   ce,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [TDATA_W-1:0]     m_tdata,
    output logic [TUSER_W-1:0]     m_tuser
);

    coord_t               coord [3];
    logic [2:0]           sat;
    logic [TDATA_W-1:0]   res_data;
    logic [TUSER_W-1:0]   res_user;
    logic                 tail_take;

    logic                 out_valid_reg, out_valid_next;
    logic [TDATA_W-1:0]   out_data_reg,  out_data_next;
    logic [TUSER_W-1:0]   out_user_reg,  out_user_next;
    logic                 skid_valid_reg, skid_valid_next;
    logic [TDATA_W-1:0]   skid_data_reg, skid_data_next;
    logic [TUSER_W-1:0]   skid_user_reg, skid_user_next;

    // Clamp each magnitude to the coordinate range and apply the sign.
    always_comb begin
        quo_t mag;
        quo_t neg_mag;
        for (int c = 0; c < 3; c++) begin
            sat[c]   = ovf[c] || (neg[c] ? (quo[c] > NEG_LIMIT) : (quo[c] > POS_LIMIT));
            mag      = sat[c] ? (neg[c] ? NEG_LIMIT : POS_LIMIT) : quo[c];
            neg_mag  = -mag;
            coord[c] = neg[c] ? neg_mag[COORD_W-1:0] : mag[COORD_W-1:0];
        end
        res_data = TDATA_W'({coord[2], coord[1], coord[0]});
        res_user = {|sat, tail_ctl.w_zero};
    end

    // The pipeline moves whenever the skid register is free.
    assign ce        = !skid_valid_reg;
    assign tail_take = ce && tail_ctl.valid;

    // Output register and skid register control.
    always_comb begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        out_user_next   = out_user_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        skid_user_next  = skid_user_reg;
        if (!out_valid_reg || m_tready) begin
            if (skid_valid_reg) begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                out_user_next   = skid_user_reg;
                skid_valid_next = 1'b0;
            end else begin
                out_valid_next = tail_take;
                out_data_next  = res_data;
                out_user_next  = res_user;
            end
        end else if (tail_take) begin
            skid_valid_next = 1'b1;
            skid_data_next  = res_data;
            skid_user_next  = res_user;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg  <= out_data_next;
        out_user_reg  <= out_user_next;
        skid_data_reg <= skid_data_next;
        skid_user_reg <= skid_user_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

endmodule

### src/homogeneous_vertex_transform.sv
// ----------------------------------------------------------------------------
// homogeneous_vertex_transform
// 4x4 homogeneous transform of a Q8.8 vertex with perspective divide.
// ----------------------------------------------------------------------------
// Usage:
//   Vertices arrive on the s_ stream, one per transaction, with x, y and z
//   packed in s_tdata. Results leave on the m_ stream: the divided x, y and
//   z in m_tdata, and the zero-w and saturation flags in m_tuser.
//   The matrix is loaded through the APB port, one 64-bit row per register
//   at byte addresses 0, 8, 16 and 24; write it only while no vertex is in
//   flight. Reads return the stored row.
//   Throughput is one vertex per clock while the receiver keeps up. Each
//   vertex passes the multiply and sum stages, the pipelined divider (one
//   quotient bit per stage plus an overflow check), and saturation into
//   the output register. Reset clears every valid bit and loads the
//   identity matrix. When the receiver stalls, one more result is caught
//   in a skid register; after that s_tready drops and the whole pipeline
//   holds until the receiver takes the waiting result.
// ----------------------------------------------------------------------------
module homogeneous_vertex_transform import hvt_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    // Input stream.
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [TDATA_W-1:0]     s_tdata,   // in_x, in_y, in_z
    // Result stream.
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [TDATA_W-1:0]     m_tdata,   // out_x, out_y, out_z
    output logic [TUSER_W-1:0]     m_tuser,   // w_was_zero, saturated
    // Configuration port.
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [APB_ADDR_W-1:0]  paddr,
    input  logic [APB_DATA_W-1:0]  pwdata,
    output logic [APB_DATA_W-1:0]  prdata,
    output logic                   pready
);

    matrix_t               matrix_reg, matrix_next;
    logic                  ce;
    hvt_ctl_t              mac_ctl;
    logic [2:0][DIV_W-1:0] num_mag;
    logic [2:0]            num_neg;
    mag_t                  den;
    logic [2:0][Q_W-1:0]   quo;
    logic [2:0]            ovf;
    logic [2:0]            neg;
    hvt_ctl_t              ctl_line_reg [DIV_STAGES];
    reg_idx_t              reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = reg_idx_t'(paddr[APB_ADDR_W-1:3]);
    assign prdata  = matrix_reg[paddr[APB_ADDR_W-1:3]];

    // Matrix row registers, written on the APB access cycle.
    always_comb begin
        matrix_next = matrix_reg;
        if (psel && penable && pwrite && pready) begin
            case (reg_idx)
                REG_ROW_X: matrix_next[REG_ROW_X] = pwdata;
                REG_ROW_Y: matrix_next[REG_ROW_Y] = pwdata;
                REG_ROW_Z: matrix_next[REG_ROW_Z] = pwdata;
                REG_ROW_W: matrix_next[REG_ROW_W] = pwdata;
                default:   matrix_next = matrix_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            matrix_reg <= MATRIX_RESET;
        end else begin
            matrix_reg <= matrix_next;
        end
    end

    assign s_tready = ce;

    // Multiply and sum front end.
    hvt_mac u_mac (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ce       (ce),
        .in_valid (s_tvalid),
        .in_x     (s_tdata[COORD_W-1:0]),
        .in_y     (s_tdata[2*COORD_W-1:COORD_W]),
        .in_z     (s_tdata[3*COORD_W-1:2*COORD_W]),
        .matrix   (matrix_reg),
        .ctl      (mac_ctl),
        .num_mag  (num_mag),
        .num_neg  (num_neg),
        .den      (den)
    );

    // One divider per coordinate, all sharing the same divisor.
    for (genvar g = 0; g < 3; g++) begin : g_lane
        hvt_div u_div (
            .aclk    (aclk),
            .ce      (ce),
            .num_mag (num_mag[g]),
            .den     (den),
            .neg_in  (num_neg[g]),
            .quo     (quo[g]),
            .ovf     (ovf[g]),
            .neg     (neg[g])
        );
    end

    // Valid bits and the zero-w flag follow the divider stages.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int s = 0; s < DIV_STAGES; s++) begin
                ctl_line_reg[s] <= '0;
            end
        end else if (ce) begin
            ctl_line_reg[0] <= mac_ctl;
            for (int s = 1; s < DIV_STAGES; s++) begin
                ctl_line_reg[s] <= ctl_line_reg[s-1];
            end
        end
    end

    // Saturation, output register and skid register.
    hvt_out u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .tail_ctl (ctl_line_reg[DIV_STAGES-1]),
        .quo      (quo),
        .ovf      (ovf),
        .neg      (neg),
        .ce       (ce),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

### src/hvt_checker.sv
// ----------------------------------------------------------------------------
// hvt_checker
// Port-level checks of the vertex transform, bound to the top level.
// ----------------------------------------------------------------------------
module hvt_port_checks import hvt_pkg::*; (
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic [TDATA_W-1:0]    s_tdata,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [TDATA_W-1:0]    m_tdata,
    input logic [TUSER_W-1:0]    m_tuser
);

    // Reset empties the pipeline and opens the input side.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && s_tready)
        else $error("result valid or input blocked after reset");

    // A result that is not taken holds still.
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // The input side closes only after the receiver refused a result.
    a_ready_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(s_tready) |-> $past(m_tvalid && !m_tready))
        else $error("input blocked without an output stall");

    // A blocked input means a result is waiting at the output.
    a_blocked_waits: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid)
        else $error("input blocked while no result is offered");

endmodule

bind homogeneous_vertex_transform hvt_port_checks u_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

### test/hvt_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// hvt_checker
// Watches the vertex, result and register ports of the homogeneous vertex
// transform. It keeps its own copy of the matrix and computes the expected
// result of every accepted vertex. Each result transaction is compared field
// by field with the oldest waiting expectation. The number of failed
// comparisons and the number of results still due go back to the testbench.
// ----------------------------------------------------------------------------
module hvt_checker import hvt_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [TDATA_W-1:0]    s_tdata,   // in_x, in_y, in_z
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [TDATA_W-1:0]    m_tdata,   // out_x, out_y, out_z
    input  logic [TUSER_W-1:0]    m_tuser,   // w_was_zero, saturated
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic                  pready,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output int                    mismatch_count,
    output int                    pending_count
);

    // Magnitudes of the most negative and the most positive coordinate.
    localparam longint unsigned MAG_NEG = 64'd1 << (COORD_W - 1);
    localparam longint unsigned MAG_POS = MAG_NEG - 64'd1;

    typedef struct packed {
        coord_t x;
        coord_t y;
        coord_t z;
        logic   w_zero;
        logic   sat;
    } vertex_out_t;

    logic [ROW_W-1:0] matrix_rows [NUM_ROWS];
    vertex_out_t      pending_vertices [$];

    // Signed coefficient of one row and column of the shadow matrix.
    function automatic longint coef_of(input int unsigned r, input int unsigned col);
        coef_t c;
        c = matrix_rows[r][col * COEF_W +: COEF_W];
        return longint'(c);
    endfunction

    function automatic longint unsigned magnitude(input longint a);
        return (a < 0) ? longint'(-a) : a;
    endfunction

    // Full-precision transform, perspective divide and clamp of one vertex.
    function automatic vertex_out_t transform_vertex(input coord_t vx, input coord_t vy,
                                                     input coord_t vz);
        longint          acc [4];
        longint unsigned mag;
        longint unsigned w_mag;
        logic            neg;
        coord_t          res [3];
        vertex_out_t     r;
        int              c;
        r.sat = 1'b0;
        for (c = 0; c < 4; c++) begin
            acc[c] = longint'(vx) * coef_of(0, c) + longint'(vy) * coef_of(1, c)
                   + longint'(vz) * coef_of(2, c) + (longint'(1) <<< FRAC_BITS) * coef_of(3, c);
        end
        r.w_zero = (acc[3] == 0);
        w_mag = magnitude(acc[3]);
        for (c = 0; c < 3; c++) begin
            // Without a usable w the sum is only brought back to the coordinate format.
            if (r.w_zero) begin
                neg = acc[c] < 0;
                mag = magnitude(acc[c]) >> FRAC_BITS;
            end else begin
                neg = (acc[c] < 0) != (acc[3] < 0);
                mag = (magnitude(acc[c]) << FRAC_BITS) / w_mag;
            end
            if (neg) begin
                if (mag > MAG_NEG) begin
                    r.sat = 1'b1;
                    mag = MAG_NEG;
                end
                res[c] = coord_t'(64'd0 - mag);
            end else begin
                if (mag > MAG_POS) begin
                    r.sat = 1'b1;
                    mag = MAG_POS;
                end
                res[c] = coord_t'(mag);
            end
        end
        r.x = res[0];
        r.y = res[1];
        r.z = res[2];
        return r;
    endfunction

    task automatic report_field(input string field, input longint want_v, input longint got_v);
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want_v, got_v);
    endtask

    // Register writes, vertex transactions and result transactions.
    always @(posedge aclk) begin : monitor
        vertex_out_t want;
        vertex_out_t got;
        if (!aresetn) begin
            matrix_rows[0] = ROW_X_RESET;
            matrix_rows[1] = ROW_Y_RESET;
            matrix_rows[2] = ROW_Z_RESET;
            matrix_rows[3] = ROW_W_RESET;
            pending_vertices.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (reg_idx_t'(paddr[APB_ADDR_W-1:3]))
                    REG_ROW_X: matrix_rows[0] = pwdata;
                    REG_ROW_Y: matrix_rows[1] = pwdata;
                    REG_ROW_Z: matrix_rows[2] = pwdata;
                    REG_ROW_W: matrix_rows[3] = pwdata;
                    default: ;
                endcase
            end

            if (s_tvalid && s_tready) begin
                pending_vertices.push_back(transform_vertex(s_tdata[0 +: COORD_W],
                                                            s_tdata[COORD_W +: COORD_W],
                                                            s_tdata[2 * COORD_W +: COORD_W]));
            end

            if (m_tvalid && m_tready) begin
                got.x      = m_tdata[0 +: COORD_W];
                got.y      = m_tdata[COORD_W +: COORD_W];
                got.z      = m_tdata[2 * COORD_W +: COORD_W];
                got.w_zero = m_tuser[0];
                got.sat    = m_tuser[1];
                if (pending_vertices.size() == 0) begin
                    $display("%0t: result with none expected, got x=%0d y=%0d z=%0d",
                             $time, got.x, got.y, got.z);
                    mismatch_count++;
                end else begin
                    want = pending_vertices.pop_front();
                    if (got !== want) begin
                        if (got.x !== want.x) report_field("out_x", want.x, got.x);
                        if (got.y !== want.y) report_field("out_y", want.y, got.y);
                        if (got.z !== want.z) report_field("out_z", want.z, got.z);
                        if (got.w_zero !== want.w_zero)
                            report_field("w_was_zero", want.w_zero, got.w_zero);
                        if (got.sat !== want.sat) report_field("saturated", want.sat, got.sat);
                        mismatch_count++;
                    end
                end
            end
        end
        pending_count = pending_vertices.size();
    end

endmodule

### test/tb_homogeneous_vertex_transform.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_homogeneous_vertex_transform
// Drives vertices through the homogeneous vertex transform under a series of
// matrices: identity, perspective, saturating scale and translation, all-zero
// and other extreme settings, then random ones. Both stream sides idle in
// random bursts except in the last phase. The checker does the comparison;
// this module loads the matrix between phases and gives the verdict.
// ----------------------------------------------------------------------------
module tb_homogeneous_vertex_transform import hvt_pkg::*; ();

    localparam int LATENCY_CYCLES = 23;
    localparam int PHASE_VERTICES = 90;
    localparam int NUM_PHASES     = 10;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [TDATA_W-1:0]    s_tdata;   // in_x, in_y, in_z
    logic                  m_tvalid;
    logic                  m_tready;
    logic [TDATA_W-1:0]    m_tdata;   // out_x, out_y, out_z
    logic [TUSER_W-1:0]    m_tuser;   // w_was_zero, saturated
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    int   failures;
    int   pending_results;
    logic quiet;

    homogeneous_vertex_transform u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    hvt_checker u_check (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .pready         (pready),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .mismatch_count (failures),
        .pending_count  (pending_results)
    );

    // Clock.
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Watchdog for a hung handshake.
    initial begin
        #5_000_000;
        $display("tb: failure");
        $finish;
    end

    // Receiver: stall bursts between ready stretches, always ready when quiet.
    initial begin
        m_tready = 1'b0;
        @(negedge aclk);
        forever begin
            if (!quiet && $urandom_range(0, 2) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(negedge aclk);
            end
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 30)) @(negedge aclk);
        end
    end

    function automatic coef_t random_coef();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return coef_t'($urandom_range(0, 1024) - 512);
            4:          return coef_t'(0);
            5, 6:       return coef_t'($urandom);
            7:          return 16'sh0100;
            8:          return 16'shFF00;
            default:    return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
        endcase
    endfunction

    function automatic logic [ROW_W-1:0] random_row();
        logic [ROW_W-1:0] row;
        int               col;
        for (col = 0; col < NUM_COLS; col++)
            row[col * COEF_W +: COEF_W] = random_coef();
        return row;
    endfunction

    function automatic coord_t random_coord();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: return coord_t'($urandom);
            5, 6, 7:       return coord_t'($urandom_range(0, 2048) - 1024);
            default: begin
                case ($urandom_range(0, 4))
                    0:       return 16'sh7FFF;
                    1:       return 16'sh8000;
                    2:       return 16'sh0000;
                    3:       return 16'sh0001;
                    default: return 16'shFFFF;
                endcase
            end
        endcase
    endfunction

    // Setup and access phases, then an idle phase so back-to-back writes stay clean.
    task automatic write_row(input reg_idx_t idx, input logic [ROW_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_ADDR_W'(idx) << 3;
        pwdata  <= value;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic wait_drained();
        while (pending_results != 0) @(negedge aclk);
    endtask

    task automatic load_matrix(input logic [ROW_W-1:0] rx, input logic [ROW_W-1:0] ry,
                               input logic [ROW_W-1:0] rz, input logic [ROW_W-1:0] rw);
        wait_drained();
        write_row(REG_ROW_X, rx);
        write_row(REG_ROW_Y, ry);
        write_row(REG_ROW_Z, rz);
        write_row(REG_ROW_W, rw);
    endtask

    // One vertex transaction, then possibly a gap with junk on the data lines.
    task automatic send_vertex(input coord_t vx, input coord_t vy, input coord_t vz);
        s_tdata  <= {vz, vy, vx};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            s_tdata  <= TDATA_W'({$urandom, $urandom});
            repeat ($urandom_range(1, 12)) @(negedge aclk);
        end
    endtask

    // Stimulus and verdict.
    initial begin : stimulus
        logic [ROW_W-1:0] rows [NUM_ROWS];
        int               p;
        int               r;
        aresetn  = 1'b0;
        quiet    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;

        // Identity after reset: coordinate extremes come back unchanged.
        send_vertex(16'sh0000, 16'sh0000, 16'sh0000);
        send_vertex(16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
        send_vertex(16'sh8000, 16'sh8000, 16'sh8000);
        send_vertex(16'sh0001, 16'shFFFF, 16'sh0100);
        send_vertex(16'sh5555, 16'shAAAA, 16'sh00FF);
        s_tvalid <= 1'b0;

        // Perspective: w follows z and the translation row is empty.
        load_matrix(64'h0000_0000_0000_0100, 64'h0000_0000_0100_0000,
                    64'h0100_0100_0000_0000, 64'h0000_0000_0000_0000);
        send_vertex(16'sh0100, 16'sh0100, 16'sh0200);
        send_vertex(16'shFD00, 16'sh0200, 16'shFF00);
        send_vertex(16'sh7FFF, 16'sh8000, 16'sh0001);
        send_vertex(16'sh0064, 16'shFF9C, 16'sh0000);
        send_vertex(16'sh0000, 16'sh0000, 16'sh8000);
        send_vertex(16'sh0003, 16'shFFFD, 16'sh0007);
        s_tvalid <= 1'b0;

        // Largest scale with extreme translation: saturation of both signs.
        load_matrix(64'h0000_0000_0000_7FFF, 64'h0000_0000_7FFF_0000,
                    64'h0000_7FFF_0000_0000, 64'h0100_8000_7FFF_8000);
        send_vertex(16'sh0000, 16'sh0000, 16'sh0000);
        send_vertex(16'sh0001, 16'sh0001, 16'sh0001);
        send_vertex(16'shFFFF, 16'shFFFF, 16'shFFFF);
        send_vertex(16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
        send_vertex(16'sh8000, 16'sh8000, 16'sh8000);
        s_tvalid <= 1'b0;

        // Zero w with the most negative coefficient on the diagonal.
        load_matrix(64'h0000_0000_0000_8000, 64'h0000_0000_0100_0000,
                    64'h0000_FF00_0000_0000, 64'h0000_0000_0000_0000);
        send_vertex(16'sh0001, 16'sh0001, 16'sh0001);
        send_vertex(16'sh8000, 16'sh7FFF, 16'sh8000);
        send_vertex(16'sh0000, 16'sh8000, 16'sh7FFF);
        send_vertex(16'shFFFF, 16'sh0080, 16'shFF80);
        s_tvalid <= 1'b0;

        // Random vertices under extreme and random matrices.
        for (p = 0; p < NUM_PHASES; p++) begin
            for (r = 0; r < NUM_ROWS; r++) begin
                case (p)
                    0:       rows[r] = 64'h7FFF_7FFF_7FFF_7FFF;
                    1:       rows[r] = 64'h8000_8000_8000_8000;
                    2:       rows[r] = 64'h0000_0000_0000_0000;
                    3:       rows[r] = 64'hFFFF_FFFF_FFFF_FFFF;
                    4:       rows[r] = random_row() & 64'h0000_FFFF_FFFF_FFFF;
                    default: rows[r] = random_row();
                endcase
            end
            quiet = (p == NUM_PHASES - 1);
            load_matrix(rows[0], rows[1], rows[2], rows[3]);
            repeat (PHASE_VERTICES) send_vertex(random_coord(), random_coord(), random_coord());
            s_tvalid <= 1'b0;
        end

        wait_drained();
        repeat (2 * LATENCY_CYCLES) @(negedge aclk);
        if (pending_results != 0)
            $display("%0t: %0d results never arrived", $time, pending_results);
        if (failures == 0 && pending_results == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
